>>> src/mmcs_pkg.sv
// mmcs_pkg: shared types and constants of the min/max contrast stretch block
// holds controller states, command/status structs and register codes
// no dependencies
`timescale 1ns / 1ps

package mmcs_pkg;

   // width of the seed registers and of the configuration data, and of a pixel
   localparam int SEED_BITS  = 32;
   localparam int PIXEL_BITS = 8;

   // restoring divider: one quotient bit per step
   localparam int QUOT_STEPS = PIXEL_BITS;
   localparam int STEP_BITS  = $clog2(QUOT_STEPS);
   localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(QUOT_STEPS - 1);

   localparam logic [PIXEL_BITS-1:0] PIXEL_ZERO = '0;
   localparam logic [PIXEL_BITS-1:0] PIXEL_FULL = '1;

   // seed reset values
   localparam logic signed [SEED_BITS-1:0] MIN_SEED_RESET = 32'sd1000000;
   localparam logic signed [SEED_BITS-1:0] MAX_SEED_RESET = 32'sd0;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MIN_SEED = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_SEED = 1'b1;

   // word kinds
   localparam logic KIND_MEASURE = 1'b0;
   localparam logic KIND_CONVERT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_LOAD,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept_meas;
      logic accept_conv;
      logic prep;
      logic load_num;
      logic div_step;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic special;
      logic div_done;
      logic out_busy;
   } sts_type;

endpackage

>>> src/mmcs_dp.sv
// mmcs_dp: datapath of the min/max contrast stretch block
// seed registers, running min/max, range set-up, restoring divider, output register
// depends on mmcs_pkg
`timescale 1ns / 1ps

module mmcs_dp import mmcs_pkg::*; #(
   parameter int SAMPLE_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [SEED_BITS-1:0]          csr_wdata,
   input  logic                          req_first,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  cmd_type                       cmd,
   output sts_type                       sts,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [PIXEL_BITS-1:0]         rsp_pixel
);

   localparam int WIDE      = (SAMPLE_BITS > SEED_BITS) ? SAMPLE_BITS : SEED_BITS;
   localparam int DIFF_BITS = WIDE + 1;
   localparam int REM_BITS  = WIDE + 2;
   localparam int NUM_BITS  = DIFF_BITS + PIXEL_BITS;

   logic signed [SEED_BITS-1:0] min_seed_ff, max_seed_ff;
   logic signed [WIDE-1:0]      run_min_ff, run_max_ff, run_min_in, run_max_in;
   logic signed [WIDE-1:0]      sample_x, base_min, base_max, x_ff;
   logic [DIFF_BITS-1:0]        d_ff, d_in, range_ff, range_in;
   logic                        zero_ff, full_ff, zero_in, full_in;
   logic [NUM_BITS-1:0]         num;
   logic [REM_BITS-1:0]         rem_ff, rem_in, rem_sh, range_ext;
   logic [PIXEL_BITS-1:0]       lo_ff, lo_in, quot_ff, quot_in;
   logic [STEP_BITS-1:0]        step_ff, step_in;
   logic                        fits;
   logic [PIXEL_BITS-1:0]       pixel_ff, pixel_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // seed registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_seed_ff <= MIN_SEED_RESET;
         max_seed_ff <= MAX_SEED_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_MIN_SEED: min_seed_ff <= csr_wdata;
            REG_MAX_SEED: max_seed_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // running min and max, reloaded from the seeds on a first measure word
   assign sample_x = WIDE'(req_sample);
   assign base_min = req_first ? WIDE'(min_seed_ff) : run_min_ff;
   assign base_max = req_first ? WIDE'(max_seed_ff) : run_max_ff;
   assign run_min_in = (sample_x < base_min) ? sample_x : base_min;
   assign run_max_in = (sample_x > base_max) ? sample_x : base_max;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_min_ff <= WIDE'(MIN_SEED_RESET);
         run_max_ff <= WIDE'(MAX_SEED_RESET);
      end else if (cmd.accept_meas) begin
         run_min_ff <= run_min_in;
         run_max_ff <= run_max_in;
      end
   end

   // convert sample capture
   always_ff @(posedge clock) begin
      if (cmd.accept_conv) begin
         x_ff <= sample_x;
      end
   end

   // range set-up and out-of-range checks
   assign zero_in  = (run_max_ff <= run_min_ff) || (x_ff <= run_min_ff);
   assign full_in  = (x_ff >= run_max_ff);
   assign d_in     = DIFF_BITS'(x_ff) - DIFF_BITS'(run_min_ff);
   assign range_in = DIFF_BITS'(run_max_ff) - DIFF_BITS'(run_min_ff);

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         zero_ff  <= zero_in;
         full_ff  <= full_in;
         d_ff     <= d_in;
         range_ff <= range_in;
      end
   end

   // numerator 255*d, then one quotient bit per step
   assign num       = {d_ff, PIXEL_ZERO} - NUM_BITS'(d_ff);
   assign range_ext = REM_BITS'(range_ff);
   assign rem_sh    = {rem_ff[REM_BITS-2:0], lo_ff[PIXEL_BITS-1]};
   assign fits      = (rem_sh >= range_ext);

   always_comb begin
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      if (cmd.load_num) begin
         rem_in  = REM_BITS'(num[NUM_BITS-1:PIXEL_BITS]);
         lo_in   = num[PIXEL_BITS-1:0];
         quot_in = PIXEL_ZERO;
         step_in = '0;
      end else if (cmd.div_step) begin
         rem_in  = fits ? (rem_sh - range_ext) : rem_sh;
         lo_in   = {lo_ff[PIXEL_BITS-2:0], 1'b0};
         quot_in = {quot_ff[PIXEL_BITS-2:0], fits};
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      lo_ff   <= lo_in;
      quot_ff <= quot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   // output register
   always_comb begin
      priority if (zero_ff) begin
         pixel_in = PIXEL_ZERO;
      end else if (full_ff) begin
         pixel_in = PIXEL_FULL;
      end else begin
         pixel_in = quot_ff;
      end
   end

   always_comb begin
      priority if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         pixel_ff <= pixel_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel = pixel_ff;

   // status back to the controller
   assign sts.special  = zero_ff || full_ff;
   assign sts.div_done = (step_ff == STEP_LAST);
   assign sts.out_busy = rsp_valid_ff && !rsp_ready;

   // restoring division keeps the partial remainder below the range
   a_rem_below_range: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (rem_ff < range_ext))
      else $error("partial remainder not below range");

   // a taken word with nothing new behind it empties the output register
   a_out_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ready && !cmd.emit) |=> !rsp_valid_ff)
      else $error("output word held after being taken");

   // a new word is never written over one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(rsp_valid_ff && !rsp_ready))
      else $error("pending output word overwritten");

endmodule

>>> src/mmcs_ctrl.sv
// mmcs_ctrl: controller of the min/max contrast stretch block
// sequences accept, range set-up, divider steps and output hand-off
// depends on mmcs_pkg
`timescale 1ns / 1ps

module mmcs_ctrl import mmcs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_kind,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_kind == KIND_CONVERT)) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = sts.special ? ST_EMIT : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (sts.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!sts.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready       = 1'b1;
            cmd.accept_meas = req_valid && (req_kind == KIND_MEASURE);
            cmd.accept_conv = req_valid && (req_kind == KIND_CONVERT);
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
         end
         ST_LOAD: begin
            cmd.load_num = !sts.special;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = !sts.out_busy;
         end
         default: ;
      endcase
   end

   // the divider hands over as soon as its last bit is in
   a_div_to_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && sts.div_done) |=> (state_ff == ST_EMIT))
      else $error("divider did not hand over after last step");

   // no work starts without an incoming word
   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !req_valid) |=> (state_ff == ST_IDLE))
      else $error("left idle without a word");

   // a taken convert word always starts the range set-up
   a_conv_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && (req_kind == KIND_CONVERT))
      |=> (state_ff == ST_PREP))
      else $error("convert word did not start set-up");

endmodule

>>> src/min_max_contrast_stretch.sv
// min_max_contrast_stretch: top level of the min/max contrast stretch block
// joins controller mmcs_ctrl and datapath mmcs_dp
// depends on mmcs_pkg, mmcs_ctrl, mmcs_dp
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_kind, req_sample, req_first
//   rsp      out        rsp_valid / rsp_ready  rsp_pixel
//   csr      in         csr_we (no wait)       csr_index, csr_wdata
//
// a measure word is taken in one cycle, back to back, and gives no result
// a convert word passes range set-up, numerator load, divider and hand-off before the next
// word is taken; a pixel of 0 or 255 by range check skips the 8-step restoring divider
// the result sits in an output register; a measure word may be taken while it waits
// reset is one synchronous cycle, no clearing pass
// a stalled rsp holds the block in its hand-off state until the word is taken
`timescale 1ns / 1ps

module min_max_contrast_stretch import mmcs_pkg::*; #(
   parameter int SAMPLE_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [SEED_BITS-1:0]          csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_first,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [PIXEL_BITS-1:0]         rsp_pixel
);

   cmd_type cmd;
   sts_type sts;

   // sequencing
   mmcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // arithmetic and storage
   mmcs_dp #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_first  (req_first),
      .req_sample (req_sample),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_pixel  (rsp_pixel)
   );

endmodule
